// ===== design/smx_pkg.sv =====
// Shared types, constants and the exponent coefficient table for the softmax vector unit.
// No dependencies; smx_front, smx_queue, smx_back and the top level import this package.
package smx_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 22;
  localparam int EXP_BITS    = 12;
  localparam int COEF_W      = 30;
  localparam int ACC_W       = 31;
  localparam int QUO_W       = 17;

  // Descriptor of one closed vector, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [VAL_W-1:0] vmax;
  } desc_t;

  // exp(-2^b/256) in Q0.30, rounded to nearest.
  function automatic logic [COEF_W-1:0] exp_coef(input logic [3:0] b);
    logic [COEF_W-1:0] c;
    unique case (b)
      4'd0:    c = 30'd1069555701;
      4'd1:    c = 30'd1065385899;
      4'd2:    c = 30'd1057095000;
      4'd3:    c = 30'd1040706261;
      4'd4:    c = 30'd1008687096;
      4'd5:    c = 30'd947573834;
      4'd6:    c = 30'd836230973;
      4'd7:    c = 30'd651257337;
      4'd8:    c = 30'd395007542;
      4'd9:    c = 30'd145315154;
      4'd10:   c = 30'd19666268;
      4'd11:   c = 30'd360200;
      default: c = 30'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/smx_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/smx_front.sv =====
// Front end: accepts elements, writes them to the element RAM and tracks the maximum.
// Depends on smx_pkg; drives the write port of the element RAM and pushes descriptors.
module smx_front #(
  parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [smx_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_last,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [smx_pkg::VAL_W-1:0]         ram_wdata,
  output logic                              push,
  output smx_pkg::desc_t                    push_desc,
  input  logic                              release_vec
);
  import smx_pkg::*;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt, cnt_inc;
  logic signed [VAL_W-1:0] max_r, max_nxt, max_new;
  logic                    held_r, held_nxt;
  logic                    accept, close;

  assign in_stall  = held_r;
  assign accept    = in_valid && !held_r;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign max_new   = (in_value > max_r) ? in_value : max_r;
  assign close     = in_last || (cnt_inc == CNT_W'(MAX_LEN));

  assign ram_we    = accept;
  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_wdata = in_value;
  assign push      = accept && close;
  assign push_desc = '{n: cnt_inc, vmax: max_new};

  always_comb begin
    cnt_nxt  = cnt_r;
    max_nxt  = max_r;
    held_nxt = held_r;
    if (release_vec) begin
      held_nxt = 1'b0;
    end
    if (accept) begin
      if (close) begin
        cnt_nxt  = '0;
        max_nxt  = {1'b1, {(VAL_W-1){1'b0}}};
        held_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        max_nxt = max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      max_r  <= {1'b1, {(VAL_W-1){1'b0}}};
      held_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      max_r  <= max_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== design/smx_queue.sv =====
// Two-entry descriptor queue between the front end and the back end.
// Depends on smx_pkg for the descriptor type.
module smx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  smx_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           not_empty,
  output logic           full,
  output smx_pkg::desc_t head
);
  import smx_pkg::*;

  desc_t      slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign head      = slot_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_desc;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/smx_back.sv =====
// Back end: exponentiates the stored elements, sums them and divides each by the sum.
// Depends on smx_pkg and one smx_ram instance (exponent store); reads the element store.
module smx_back #(
  parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  smx_pkg::desc_t             q_head,
  output logic                       q_pop,
  output logic [AW-1:0]              elem_raddr,
  input  logic [smx_pkg::VAL_W-1:0]  elem_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [smx_pkg::VAL_W-1:0]  out_prob,
  output logic                       out_last_out,
  output logic                       release_vec
);
  import smx_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_LD1  = 4'd2;
  localparam logic [3:0] S_EXP  = 4'd3;
  localparam logic [3:0] S_EFIN = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_LD2  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]              st_r, st_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic signed [VAL_W-1:0] max_r, max_nxt;
  logic [EXP_BITS-1:0]     k_r, k_nxt;
  logic [3:0]              b_r, b_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SUM_W:0]          rem_r, rem_nxt;
  logic [QUO_W-1:0]        nb_r, nb_nxt, quo_r, quo_nxt;
  logic [4:0]              dc_r, dc_nxt;
  logic [VAL_W-1:0]        prob_r, prob_nxt;

  logic                    is_last;
  logic signed [VAL_W:0]   diff;
  logic [ACC_W+COEF_W-1:0] prod;
  logic [ACC_W-1:0]        acc_rnd;
  logic [VAL_W:0]          e_full;
  logic [VAL_W-1:0]        e_sat;
  logic                    ev_we;
  logic [VAL_W-1:0]        ev_rdata;
  logic [SUM_W:0]          trial;

  assign is_last    = ({{(CNT_W-AW){1'b0}}, idx_r} == (n_r - CNT_W'(1)));
  assign elem_raddr = idx_r;
  assign diff       = {max_r[VAL_W-1], max_r} - {elem_rdata[VAL_W-1], elem_rdata};
  assign prod       = acc_r * exp_coef(b_r) + (ACC_W+COEF_W)'(1 << 29);
  assign acc_rnd    = prod[30 +: ACC_W];
  assign e_full     = acc_r[ACC_W-1:14] + (VAL_W+1)'(acc_r[13]);
  assign e_sat      = e_full[VAL_W] ? {VAL_W{1'b1}} : e_full[VAL_W-1:0];
  assign ev_we      = (st_r == S_EFIN);
  assign trial      = {rem_r[SUM_W-1:0], nb_r[QUO_W-1]};

  assign q_pop        = (st_r == S_IDLE) && q_not_empty;
  assign out_valid    = (st_r == S_OUT);
  assign out_prob     = prob_r;
  assign out_last_out = is_last;
  assign release_vec  = (st_r == S_OUT) && !out_stall && is_last;

  smx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_ev_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (idx_r),
    .wdata (e_sat),
    .raddr (idx_r),
    .rdata (ev_rdata)
  );

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    n_nxt    = n_r;
    max_nxt  = max_r;
    k_nxt    = k_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    sum_nxt  = sum_r;
    rem_nxt  = rem_r;
    nb_nxt   = nb_r;
    quo_nxt  = quo_r;
    dc_nxt   = dc_r;
    prob_nxt = prob_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_not_empty) begin
          n_nxt   = q_head.n;
          max_nxt = q_head.vmax;
          idx_nxt = '0;
          sum_nxt = '0;
          st_nxt  = S_RD1;
        end
      end
      S_RD1: st_nxt = S_LD1;
      S_LD1: begin
        k_nxt   = diff[EXP_BITS-1:0];
        b_nxt   = '0;
        acc_nxt = ACC_W'(1 << 30);
        // Differences of 16.0 or more underflow to zero.
        if (diff[VAL_W:EXP_BITS] != '0) begin
          acc_nxt = '0;
          st_nxt  = S_EFIN;
        end else begin
          st_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (k_r[b_r]) begin
          acc_nxt = acc_rnd;
        end
        b_nxt = b_r + 4'd1;
        if (b_r == 4'(EXP_BITS - 1)) begin
          st_nxt = S_EFIN;
        end
      end
      S_EFIN: begin
        sum_nxt = sum_r + SUM_W'(e_sat);
        if (is_last) begin
          idx_nxt = '0;
          st_nxt  = S_RD2;
        end else begin
          idx_nxt = idx_r + AW'(1);
          st_nxt  = S_RD1;
        end
      end
      S_RD2: st_nxt = S_LD2;
      S_LD2: begin
        // The quotient is below 2^17, so the top bits of e<<16 start as the remainder.
        rem_nxt = (SUM_W+1)'(ev_rdata[VAL_W-1:1]);
        nb_nxt  = {ev_rdata[0], {(QUO_W-1){1'b0}}};
        quo_nxt = '0;
        dc_nxt  = '0;
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, sum_r}) begin
          rem_nxt = trial - {1'b0, sum_r};
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        nb_nxt = {nb_r[QUO_W-2:0], 1'b0};
        dc_nxt = dc_r + 5'd1;
        if (dc_r == 5'(QUO_W - 1)) begin
          prob_nxt = quo_nxt[QUO_W-1] ? {VAL_W{1'b1}} : quo_nxt[VAL_W-1:0];
          st_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (is_last) begin
            st_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            st_nxt  = S_RD2;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    max_r  <= max_nxt;
    k_r    <= k_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    nb_r   <= nb_nxt;
    quo_r  <= quo_nxt;
    dc_r   <= dc_nxt;
    prob_r <= prob_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== design/softmax_vector_unit.sv =====
// Top level of the softmax vector unit: front end, descriptor queue, back end, element RAM.
// Depends on smx_pkg, smx_ram, smx_front, smx_queue and smx_back.
//
// Elements enter on the in_ channel (in_value signed Q8.8, in_last), one per transaction,
// and are written straight into the element RAM while the front end keeps the maximum.
// A vector closes on in_last or on its MAX_LEN-th element; in_stall then stays high
// until the last probability of that vector has been taken on the out_ channel.
// While a vector is open an element is accepted every cycle in which in_valid is high.
// The back end first runs every element through the exponent unit (one 31x30 multiply
// per cycle), summing the results, then divides each exponent by the sum with a
// restoring divider at one quotient bit per cycle, and emits each result before it
// reads the next exponent.
// Results appear in arrival order on out_prob (unsigned Q0.16) with out_last_out on the
// final one. While out_stall is high the result is held and the back end waits.
// Reset clears the control state and the maximum; the RAM contents are not cleared.
module softmax_vector_unit #(
  parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [smx_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smx_pkg::VAL_W-1:0]         out_prob,
  output logic                              out_last_out
);
  import smx_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic             ram_we, push, pop, q_not_empty, q_full, release_vec;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  desc_t            push_desc, q_head;

  smx_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_value, .in_last,
    .ram_we, .ram_waddr, .ram_wdata, .push, .push_desc, .release_vec
  );

  smx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_elem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smx_queue u_queue (
    .clk, .rst_n, .push, .push_desc, .pop,
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  smx_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .q_not_empty, .q_head,
    .q_pop        (pop),
    .elem_raddr   (ram_raddr),
    .elem_rdata   (ram_rdata),
    .out_valid, .out_stall, .out_prob, .out_last_out, .release_vec
  );

  // The front end must stay held while the back end is emitting a vector.
  a_held_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("element accepted while a vector is being emitted");

  // A descriptor is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("descriptor queue overflow");

  // Closing a vector holds the input in the next cycle.
  a_close_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> in_stall)
    else $error("input not held after a vector closed");

endmodule
